// ----- rtl/bba_pkg.sv -----
package bba_pkg;

	localparam int DATA_W         = 32;
	localparam int CNT_W          = 6;
	localparam int WORD_W         = 8;
	localparam int BIT_W          = $clog2(WORD_W);
	localparam int REG_IDX_W      = 2;
	localparam int MAX_BLOCKS_DEF = 32;

	localparam logic [WORD_W-1:0] WORD_FULL = 8'hFF;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BASE  = 2'd0,
		REG_POOL  = 2'd1,
		REG_COUNT = 2'd2
	} reg_idx_t;

endpackage

// ----- rtl/bba_div.sv -----
module bba_div
	import bba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   diff;

	// one restoring step per cycle, dividend bits shift out of the quotient register
	always_comb begin
		rem_sh = {rem_q, quo_q[DATA_W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(DATA_W - 1);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/bitmap_block_allocator.sv -----
// fixed-size block allocator over a pool cut into equal blocks, one used bit per block
// configuration: write port (cfg_wen, cfg_index, cfg_wdata), index 0 base address,
//   1 pool size, 2 block count; any such write clears the map and the use count and
//   recomputes the block size with the serial divider, during which in_ready stays low
// input channel: in_valid/in_ready transfer of opcode and free_address
// output channel: out_valid/out_ready transfer of status, block_address, blocks_in_use;
//   exactly one result per input transfer, in order, unless a configuration write drops it
// an allocate finds the lowest non-full map word from per-word full flags, then does one
//   read-modify-write of the map memory, a registered multiply by the block index and
//   an add of the base address
// a free runs the 32-step serial divider that turns the offset into a block index, then
//   one read-modify-write of the map memory
// one item is in work at a time; the next is taken once the previous result sits
//   in the output register
// a request turned away at once (pool full, free below base or zero block size) skips the map
// receiver stall: the finished result holds in the output register, a following
//   item runs to completion and then waits until the output register is free
// reset: state idle, other control registers zero, map empty, block count and size zero so
//   every allocate reports pool full and every free reports invalid free until configured
module bitmap_block_allocator
	import bba_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic [DATA_W-1:0]    free_address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [DATA_W-1:0]    block_address,
	output logic [CNT_W-1:0]     blocks_in_use
);

	localparam int NWORDS = MAX_BLOCKS / WORD_W;
	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SIZE  = 8'b0000_0010,
		S_ALOOK = 8'b0000_0100,
		S_AMOD  = 8'b0000_1000,
		S_AADD  = 8'b0001_0000,
		S_FDIV  = 8'b0010_0000,
		S_FCHK  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t              state_q;

	// configuration and derived sizing
	logic [DATA_W-1:0]   base_q;
	logic [DATA_W-1:0]   pool_q;
	logic [CNT_W-1:0]    count_q;
	logic [DATA_W-1:0]   bb_q;
	logic                size_pend_q;
	logic [CNT_W-1:0]    n_eff;
	logic                cfg_hit;

	// allocation state besides the map memory
	logic [CNT_W-1:0]    used_cnt_q;
	logic [NWORDS-1:0]   word_vld_q;
	logic [NWORDS-1:0]   full_q;

	// item in work
	logic [WA_W-1:0]     wa_q;
	logic [BIT_W-1:0]    bit_q;
	logic [DATA_W-1:0]   prod_q;
	status_t             res_status_q;
	logic [DATA_W-1:0]   res_addr_q;

	// output register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [DATA_W-1:0]   out_addr_q;
	logic [CNT_W-1:0]    out_count_q;

	// map memory, one used bit per block, eight blocks to a word
	logic [WORD_W-1:0]   mem [NWORDS];
	logic [WORD_W-1:0]   mem_rd_q;
	logic                rd_vld_q;
	logic                mem_re;
	logic [WA_W-1:0]     mem_ra;
	logic                mem_we;
	logic [WA_W-1:0]     mem_wa;
	logic [WORD_W-1:0]   mem_wd;
	logic [WORD_W-1:0]   rd_word;

	// divider hookup, shared by sizing and free
	logic                div_start;
	logic [DATA_W-1:0]   div_dividend;
	logic [DATA_W-1:0]   div_divisor;
	logic                div_done;
	logic [DATA_W-1:0]   div_quo;

	logic                in_fire;
	logic                free_ok;
	logic                idx_ok;
	logic [WA_W-1:0]     free_wa;
	logic [BIT_W-1:0]    zero_bit;
	logic [IDX_W-1:0]    alloc_idx;

	// count above the map size saturates
	assign n_eff   = (int'(count_q) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : count_q;
	assign cfg_hit = cfg_wen && (cfg_index == REG_BASE || cfg_index == REG_POOL ||
		cfg_index == REG_COUNT);

	assign in_ready = (state_q == S_IDLE) && !size_pend_q && !cfg_wen;
	assign in_fire  = in_valid && in_ready;
	assign free_ok  = (free_address >= base_q) && (bb_q != '0);
	assign idx_ok   = div_quo < DATA_W'(n_eff);

	// a word never written since the last clear reads as empty
	assign rd_word = rd_vld_q ? mem_rd_q : '0;

	// lowest word that still has a free block
	always_comb begin
		free_wa = '0;
		for (int i = NWORDS - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				free_wa = WA_W'(i);
			end
		end
	end

	// lowest clear bit of the word just read
	always_comb begin
		zero_bit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (!rd_word[b]) begin
				zero_bit = BIT_W'(b);
			end
		end
	end

	assign alloc_idx = IDX_W'({wa_q, zero_bit});

	// sizing runs only while no item is in work, so the operand choice is exclusive
	always_comb begin
		div_start    = ((state_q == S_IDLE) && size_pend_q && !cfg_wen && (n_eff != '0)) ||
			(in_fire && (opcode == OP_FREE) && free_ok);
		div_dividend = size_pend_q ? pool_q : (free_address - base_q);
		div_divisor  = size_pend_q ? DATA_W'(n_eff) : bb_q;
	end

	// memory port control
	always_comb begin
		mem_re = 1'b0;
		mem_ra = free_wa;
		mem_we = 1'b0;
		mem_wa = wa_q;
		mem_wd = rd_word;
		unique case (state_q)
			S_ALOOK: begin
				mem_re = 1'b1;
			end
			S_FDIV: begin
				mem_re = div_done && idx_ok;
				mem_ra = WA_W'(div_quo >> BIT_W);
			end
			S_AMOD: begin
				mem_we = 1'b1;
				mem_wd = rd_word | (WORD_W'(1) << zero_bit);
			end
			S_FCHK: begin
				mem_we = rd_word[bit_q];
				mem_wd = rd_word & ~(WORD_W'(1) << bit_q);
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_ra];
		end
	end

	// per-word written and full flags, cleared at once by any configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
			full_q     <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (mem_re) begin
				rd_vld_q <= word_vld_q[mem_ra];
			end
			if (cfg_hit) begin
				word_vld_q <= '0;
				full_q     <= '0;
			end else if (mem_we) begin
				word_vld_q[mem_wa] <= 1'b1;
				full_q[mem_wa]     <= (mem_wd == WORD_FULL);
			end
		end
	end

	bba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			base_q       <= '0;
			pool_q       <= '0;
			count_q      <= '0;
			bb_q         <= '0;
			size_pend_q  <= 1'b0;
			used_cnt_q   <= '0;
			wa_q         <= '0;
			bit_q        <= '0;
			prod_q       <= '0;
			res_status_q <= ST_OK;
			res_addr_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_addr_q   <= '0;
			out_count_q  <= '0;
		end else begin
			// a finished item refills the output register in the same cycle
			if (out_valid_q && out_ready && (cfg_hit || state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				if (cfg_index == REG_BASE) begin
					base_q <= cfg_wdata;
				end else if (cfg_index == REG_POOL) begin
					pool_q <= cfg_wdata;
				end else begin
					count_q <= cfg_wdata[CNT_W-1:0];
				end
				used_cnt_q  <= '0;
				size_pend_q <= 1'b1;
				state_q     <= S_IDLE;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (size_pend_q) begin
							size_pend_q <= 1'b0;
							if (n_eff == '0) begin
								bb_q <= '0;
							end else begin
								state_q <= S_SIZE;
							end
						end else if (in_fire) begin
							res_addr_q <= '0;
							if (opcode == OP_ALLOC) begin
								if (used_cnt_q < n_eff) begin
									state_q <= S_ALOOK;
								end else begin
									res_status_q <= ST_FULL;
									state_q      <= S_DONE;
								end
							end else if (free_ok) begin
								state_q <= S_FDIV;
							end else begin
								res_status_q <= ST_BAD_FREE;
								state_q      <= S_DONE;
							end
						end
					end
					S_SIZE: begin
						if (div_done) begin
							bb_q    <= div_quo;
							state_q <= S_IDLE;
						end
					end
					S_ALOOK: begin
						wa_q    <= free_wa;
						state_q <= S_AMOD;
					end
					S_AMOD: begin
						prod_q     <= DATA_W'(bb_q * DATA_W'(alloc_idx));
						used_cnt_q <= used_cnt_q + 1'b1;
						state_q    <= S_AADD;
					end
					S_AADD: begin
						res_addr_q   <= base_q + prod_q;
						res_status_q <= ST_OK;
						state_q      <= S_DONE;
					end
					S_FDIV: begin
						if (div_done) begin
							if (idx_ok) begin
								wa_q    <= WA_W'(div_quo >> BIT_W);
								bit_q   <= div_quo[BIT_W-1:0];
								state_q <= S_FCHK;
							end else begin
								res_status_q <= ST_BAD_FREE;
								state_q      <= S_DONE;
							end
						end
					end
					S_FCHK: begin
						if (rd_word[bit_q]) begin
							used_cnt_q   <= used_cnt_q - 1'b1;
							res_status_q <= ST_OK;
						end else begin
							res_status_q <= ST_BAD_FREE;
						end
						state_q <= S_DONE;
					end
					S_DONE: begin
						if (!out_valid_q || out_ready) begin
							out_valid_q  <= 1'b1;
							out_status_q <= res_status_q;
							out_addr_q   <= res_addr_q;
							out_count_q  <= used_cnt_q;
							state_q      <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign block_address = out_addr_q;
	assign blocks_in_use = out_count_q;

endmodule

// ----- rtl/bba_checker.sv -----
module bba_checker
	import bba_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic [DATA_W-1:0] block_address,
	input logic [CNT_W-1:0]  blocks_in_use
);

	logic [1:0] pend_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_fire && !out_fire) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_fire && !in_fire) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(block_address) && $stable(blocks_in_use))
		else $error("result changed while stalled");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> block_address == '0)
		else $error("address given with a failing status");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without an outstanding item");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> !in_ready)
		else $error("item taken while one waits and one is in work");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

// ----- bench/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 800_000;
	localparam int unsigned RANDOM_PHASES   = 13;
	localparam int unsigned ITEMS_PER_PHASE = 112;
	localparam int unsigned DRAIN_CYCLES    = 60;

	// one expected answer per request transfer
	typedef struct packed {
		status_t           st;
		logic [DATA_W-1:0] addr;
		logic [CNT_W-1:0]  in_use;
	} alloc_answer_t;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 cfg_wen      = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index    = REG_BASE;
	logic [DATA_W-1:0]    cfg_wdata    = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic                 opcode       = OP_ALLOC;
	logic [DATA_W-1:0]    free_address = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [1:0]           status;
	logic [DATA_W-1:0]    block_address;
	logic [CNT_W-1:0]     blocks_in_use;

	// shadow of the allocator: registers, derived block size and the used map
	logic [DATA_W-1:0]         pool_base    = '0;
	logic [DATA_W-1:0]         pool_bytes   = '0;
	logic [CNT_W-1:0]          count_reg    = '0;
	logic [DATA_W-1:0]         block_bytes  = '0;
	logic [MAX_BLOCKS_DEF-1:0] taken_map    = '0;
	logic [CNT_W-1:0]          blocks_taken = '0;

	alloc_answer_t answers_due[$];

	// idling limits for each side, changed from phase to phase
	int unsigned tx_max_gap   = 14;
	int unsigned rx_max_stall = 14;
	// long receiver hold-off asked for by the stall test, taken over by the receiver
	int unsigned hold_request = 0;
	int unsigned rx_wait      = 0;
	int unsigned fail_count   = 0;
	int unsigned cycle_count  = 0;

	bitmap_block_allocator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.free_address  (free_address),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.block_address (block_address),
		.blocks_in_use (blocks_in_use)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// guard against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[bitmap_block_allocator] ERROR");
			$finish;
		end
	end

	// count above the map size saturates
	function automatic int unsigned live_blocks();
		return (count_reg > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : count_reg;
	endfunction

	// works out the answer to one request and moves the shadow state on
	function automatic alloc_answer_t predict_answer(opcode_t op, logic [DATA_W-1:0] addr);
		alloc_answer_t     ans;
		int unsigned       live;
		logic [DATA_W-1:0] idx;
		bit                found;
		live     = live_blocks();
		ans.addr = '0;
		found    = 1'b0;
		if (op == OP_ALLOC) begin
			ans.st = ST_FULL;
			if (blocks_taken < live) begin
				// lowest free block wins
				for (int unsigned i = 0; i < live; i++) begin
					if (!found && !taken_map[i]) begin
						found        = 1'b1;
						taken_map[i] = 1'b1;
						blocks_taken = blocks_taken + 1'b1;
						ans.addr     = pool_base + block_bytes * i;
						ans.st       = ST_OK;
					end
				end
			end
		end else begin
			// below base, zero block size, index past the end or a free block: nothing changes
			ans.st = ST_BAD_FREE;
			if (addr >= pool_base && block_bytes != 0) begin
				idx = (addr - pool_base) / block_bytes;
				if (idx < live) begin
					if (taken_map[idx[4:0]]) begin
						taken_map[idx[4:0]] = 1'b0;
						blocks_taken        = blocks_taken - 1'b1;
						ans.st              = ST_OK;
					end
				end
			end
		end
		ans.in_use = blocks_taken;
		return ans;
	endfunction

	// some address inside a block that is currently taken: start, last byte or anywhere
	function automatic logic [DATA_W-1:0] used_block_address();
		int unsigned       start, k, slot;
		logic [DATA_W-1:0] off;
		bit                found;
		start = $urandom_range(MAX_BLOCKS_DEF - 1, 0);
		slot  = 0;
		found = 1'b0;
		for (int unsigned j = 0; j < MAX_BLOCKS_DEF; j++) begin
			k = (start + j) % MAX_BLOCKS_DEF;
			if (!found && taken_map[k]) begin
				found = 1'b1;
				slot  = k;
			end
		end
		case ($urandom_range(2, 0))
			0: off = '0;
			1: off = block_bytes - 1'b1;
			default: off = (block_bytes == 0) ? '0 : $urandom_range(block_bytes - 1, 0);
		endcase
		return pool_base + block_bytes * slot + off;
	endfunction

	// one request transfer; valid is only dropped when a gap is drawn
	task automatic send_item(opcode_t op, logic [DATA_W-1:0] addr);
		int unsigned gap;
		gap = $urandom_range(tx_max_gap, 0);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		free_address <= addr;
		do @(posedge clk); while (!in_ready);
		answers_due.push_back(predict_answer(op, addr));
	endtask

	// stop offering and wait until every answer has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	// register write; each one clears the map and resizes the blocks
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_BASE:  pool_base  = value;
			REG_POOL:  pool_bytes = value;
			REG_COUNT: count_reg  = value[CNT_W-1:0];
			default: ;
		endcase
		taken_map    = '0;
		blocks_taken = '0;
		block_bytes  = (live_blocks() != 0) ? pool_bytes / live_blocks() : '0;
		// divider runs with the input held off, give it time to drop ready first
		repeat (2) @(posedge clk);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic configure(logic [DATA_W-1:0] base, logic [DATA_W-1:0] pool,
			logic [CNT_W-1:0] count);
		write_reg(REG_BASE, base);
		write_reg(REG_POOL, pool);
		write_reg(REG_COUNT, {{(DATA_W-CNT_W){1'b0}}, count});
	endtask

	// straight out of reset: no blocks, so nothing can be taken or given back
	task automatic test_unconfigured();
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, '0);
		send_item(OP_FREE, '1);
	endtask

	// eight blocks of 256 bytes from 0x1000
	task automatic test_directed_allocs();
		drain();
		configure(32'h0000_1000, 32'h0000_0800, 6'd8);
		// fill the pool, then one more which must report full
		for (int i = 0; i < 9; i++)
			send_item(OP_ALLOC, (i % 2 != 0) ? '1 : '0);
		send_item(OP_FREE, 32'h0000_137F);   // middle of block 3
		send_item(OP_FREE, 32'h0000_1300);   // block 3 again, already free
		send_item(OP_FREE, 32'h0000_0FFF);   // just below base
		send_item(OP_FREE, 32'h0000_1800);   // first byte past the pool
		send_item(OP_FREE, 32'hFFFF_FFFF);   // far past the pool
		send_item(OP_ALLOC, '0);             // takes block 3 back
		send_item(OP_FREE, 32'h0000_17FF);   // last byte of the last block
	endtask

	task automatic test_degenerate_sizes();
		drain();
		// pool smaller than the count: block size truncates to zero, all at base
		configure(32'h8000_0000, 32'd5, 6'd8);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '1);
		send_item(OP_FREE, 32'h8000_0000);
		drain();
		// count zero: every request fails
		write_reg(REG_COUNT, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, 32'h8000_0000);
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_output_stall();
		drain();
		configure(32'h2000_0000, 32'h0001_0000, 6'd16);
		tx_max_gap   = 0;
		hold_request = 400;
		for (int i = 0; i < 30; i++) begin
			if (i % 3 == 2 && blocks_taken != 0)
				send_item(OP_FREE, used_block_address());
			else
				send_item(OP_ALLOC, $urandom());
		end
		drain();
		tx_max_gap = 14;
	endtask

	// phases of random traffic, each on a fresh setting; most frees hit taken blocks
	task automatic test_random_traffic();
		logic [DATA_W-1:0] base, pool;
		logic [CNT_W-1:0]  count;
		int unsigned       alloc_pct, pick;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain();
			case ($urandom_range(5, 0))
				0: begin tx_max_gap = 0;  rx_max_stall = 0;  end
				1: begin tx_max_gap = 14; rx_max_stall = 0;  end
				2: begin tx_max_gap = 0;  rx_max_stall = 14; end
				default: begin tx_max_gap = 14; rx_max_stall = 14; end
			endcase
			if (phase == 0) begin
				// top of the address space, count saturating, answers wrap round
				configure('1, '1, 6'd63);
			end else if (phase == 1) begin
				configure('0, '1, 6'd32);
			end else if ($urandom_range(3, 0) == 0) begin
				// a lone base write still clears the map
				write_reg(REG_BASE, $urandom());
			end else begin
				case ($urandom_range(9, 0))
					0: count = '0;
					1: count = 6'($urandom_range(63, 33));
					2: count = 6'd32;
					default: count = 6'($urandom_range(32, 1));
				endcase
				case ($urandom_range(2, 0))
					0: base = '0;
					1: base = 32'hFFFF_FFFF - $urandom_range(65535, 0);
					default: base = $urandom();
				endcase
				case ($urandom_range(3, 0))
					0: pool = $urandom();
					1: pool = $urandom_range(4096, 0);
					2: pool = '1;
					default: pool = $urandom_range(64, 1) * 32'(count);
				endcase
				configure(base, pool, count);
			end
			alloc_pct = (phase < 2) ? 70 : $urandom_range(70, 30);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(99, 0);
				if (pick < alloc_pct) begin
					send_item(OP_ALLOC, $urandom());
				end else if (pick < 90 && blocks_taken != 0) begin
					send_item(OP_FREE, used_block_address());
				end else begin
					// noise: wild address, below base, past the end, or a block start
					case ($urandom_range(3, 0))
						0: send_item(OP_FREE, $urandom());
						1: send_item(OP_FREE, pool_base - 1'b1 - $urandom_range(255, 0));
						2: send_item(OP_FREE, pool_base + block_bytes * live_blocks()
								+ $urandom_range(255, 0));
						default: send_item(OP_FREE,
								pool_base + block_bytes * $urandom_range(31, 0));
					endcase
				end
			end
		end
	endtask

	// result side: check each transfer against the oldest expectation, then draw a stall
	always @(posedge clk) begin : result_side
		alloc_answer_t due;
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				$error("unexpected result transfer: status %0d, block_address %h",
						status, block_address);
				fail_count++;
			end else begin
				due = answers_due.pop_front();
				if (status !== due.st) begin
					$error("status: expected %0d, got %0d", due.st, status);
					fail_count++;
				end
				if (block_address !== due.addr) begin
					$error("block_address: expected %h, got %h", due.addr, block_address);
					fail_count++;
				end
				if (blocks_in_use !== due.in_use) begin
					$error("blocks_in_use: expected %0d, got %0d", due.in_use, blocks_in_use);
					fail_count++;
				end
			end
			rx_wait = $urandom_range(rx_max_stall, 0);
		end
		// long hold-off takes over whatever stall is running
		if (hold_request != 0) begin
			rx_wait      = hold_request;
			hold_request = 0;
		end
		if (rx_wait != 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unconfigured();
		test_directed_allocs();
		test_degenerate_sizes();
		test_output_stall();
		test_random_traffic();
		drain();
		// catch any stray result after the last one expected
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[bitmap_block_allocator] OK");
		end else begin
			$display("[bitmap_block_allocator] ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/bba_pkg.sv
rtl/bba_div.sv
rtl/bitmap_block_allocator.sv
rtl/bba_checker.sv
bench/testbench.sv
